@@ hdl/szs_pkg.sv @@
// shared constants, config struct and register indexes for the safezone stop block
package szs_pkg;

  localparam int MAX_LOOKBACK = 64;
  localparam int MAX_HOLD     = 32;
  localparam int WIN_DEPTH    = MAX_LOOKBACK + 1;
  localparam int IDX_CAP      = MAX_LOOKBACK + 2;

  localparam int PRICE_W    = 32;
  localparam int STOP_W     = 48;
  localparam int COEF_W     = 16;
  localparam int LB_W       = 7;
  localparam int HC_W       = 6;
  localparam int FRAC_SHIFT = 8;

  localparam int WIN_AW  = $clog2(WIN_DEPTH);
  localparam int HIST_AW = $clog2(MAX_HOLD);
  localparam int CNT_W   = $clog2(MAX_LOOKBACK + 1);
  localparam int SUM_W   = PRICE_W + CNT_W - 1;
  localparam int IDX_W   = $clog2(IDX_CAP + 1);
  localparam int HVAL_W  = $clog2(MAX_HOLD + 1);
  localparam int PROD_W  = COEF_W + PRICE_W;
  localparam int OFS_W   = PROD_W - FRAC_SHIFT;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT = 2'd3;

  typedef struct packed {
    logic              mode_short;
    logic [LB_W-1:0]   lookback;
    logic [HC_W-1:0]   hold_count;
    logic [COEF_W-1:0] coefficient;
  } cfg_t;

endpackage

@@ hdl/szs_div.sv @@
// restoring divider, one quotient bit per cycle, for the mean penetration
module szs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [szs_pkg::SUM_W-1:0]   dividend,
  input  logic [szs_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [szs_pkg::SUM_W-1:0]   quotient
);

  logic                         busy;
  logic [szs_pkg::STEP_W-1:0]   step;
  logic [szs_pkg::SUM_W-1:0]    acc;
  logic [szs_pkg::CNT_W-1:0]    rem;
  logic [szs_pkg::CNT_W-1:0]    dvs;
  logic [szs_pkg::CNT_W:0]      rem_sh;
  logic [szs_pkg::CNT_W:0]      rem_sub;
  logic                         ge;

  assign rem_sh  = {rem, acc[szs_pkg::SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // remainder stays below the divisor, so it fits back in CNT_W bits
        rem <= ge ? rem_sub[szs_pkg::CNT_W-1:0] : rem_sh[szs_pkg::CNT_W-1:0];
        acc <= {acc[szs_pkg::SUM_W-2:0], ge};
        if (step == szs_pkg::STEP_W'(szs_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign quotient = acc;

endmodule

@@ hdl/szs_core.sv @@
// sequencer, bar window memory and stop history memory of the safezone stop
module szs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  szs_pkg::cfg_t                 cfg,
  input  logic                          clr_hist,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [szs_pkg::PRICE_W-1:0]   in_high,
  input  logic [szs_pkg::PRICE_W-1:0]   in_low,
  input  logic                          in_new,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [szs_pkg::STOP_W-1:0]    res_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_RAW   = 8'b0001_0000,
    S_HOLD  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_STORE = 8'b1000_0000
  } state_t;

  state_t state;

  logic [2*szs_pkg::PRICE_W-1:0] win_mem [szs_pkg::WIN_DEPTH];
  logic [szs_pkg::STOP_W-1:0]    hist_mem [szs_pkg::MAX_HOLD];

  logic [szs_pkg::PRICE_W-1:0]   bar_hi;
  logic [szs_pkg::PRICE_W-1:0]   bar_lo;
  logic [szs_pkg::IDX_W-1:0]     bar_index;
  logic [szs_pkg::WIN_AW-1:0]    wp;
  logic [szs_pkg::WIN_AW-1:0]    scan_addr;
  logic [szs_pkg::WIN_AW-1:0]    scan_left;
  logic                          rd_vld;
  logic                          rd_first;
  logic [2*szs_pkg::PRICE_W-1:0] win_rd;
  logic [szs_pkg::PRICE_W-1:0]   base;
  logic [szs_pkg::PRICE_W-1:0]   last;
  logic [szs_pkg::SUM_W-1:0]     sum;
  logic [szs_pkg::CNT_W-1:0]     cnt;
  logic [szs_pkg::PRICE_W-1:0]   mean;
  logic [szs_pkg::PROD_W-1:0]    prod;
  logic signed [szs_pkg::STOP_W-1:0] raw;
  logic signed [szs_pkg::STOP_W-1:0] held;
  logic [szs_pkg::HIST_AW-1:0]   hp;
  logic [szs_pkg::HVAL_W-1:0]    stops_valid;
  logic [szs_pkg::HIST_AW-1:0]   h_addr;
  logic [szs_pkg::HVAL_W-1:0]    h_left;
  logic                          h_vld;
  logic [szs_pkg::STOP_W-1:0]    hist_rd;

  logic [szs_pkg::LB_W-1:0]      lb_c;
  logic [szs_pkg::LB_W-1:0]      lb_p1;
  logic [szs_pkg::HC_W-1:0]      hc_c;
  logic [szs_pkg::HVAL_W-1:0]    hold_n;
  logic [szs_pkg::IDX_W-1:0]     bidx_eff;
  logic                          warm;
  logic [szs_pkg::PRICE_W-1:0]   sel;
  logic                          pen_hit;
  logic [szs_pkg::PRICE_W-1:0]   pen_amt;
  logic [szs_pkg::OFS_W-1:0]     offset;
  logic signed [szs_pkg::STOP_W-1:0] raw_calc;
  logic                          scan_end;
  logic                          div_start;
  logic                          div_done;
  logic [szs_pkg::SUM_W-1:0]     div_q;
  logic                          win_we;
  logic                          hist_we;
  logic                          accept;

  szs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (cfg.lookback == '0) begin
      lb_c = szs_pkg::LB_W'(1);
    end else if (cfg.lookback > szs_pkg::LB_W'(szs_pkg::MAX_LOOKBACK)) begin
      lb_c = szs_pkg::LB_W'(szs_pkg::MAX_LOOKBACK);
    end else begin
      lb_c = cfg.lookback;
    end
    if (cfg.hold_count > szs_pkg::HC_W'(szs_pkg::MAX_HOLD)) begin
      hc_c = szs_pkg::HC_W'(szs_pkg::MAX_HOLD);
    end else begin
      hc_c = cfg.hold_count;
    end
  end

  assign lb_p1    = lb_c + szs_pkg::LB_W'(1);
  assign bidx_eff = in_new ? '0 : bar_index;
  assign warm     = bidx_eff >= szs_pkg::IDX_W'(lb_p1);
  assign hold_n   = (szs_pkg::HVAL_W'(hc_c) < stops_valid) ? szs_pkg::HVAL_W'(hc_c)
                                                            : stops_valid;

  // window entry holds low in the upper half, high in the lower half
  assign sel     = cfg.mode_short ? win_rd[szs_pkg::PRICE_W-1:0]
                                  : win_rd[2*szs_pkg::PRICE_W-1:szs_pkg::PRICE_W];
  // last is the newer bar, sel the one before it
  assign pen_hit = cfg.mode_short ? (last > sel) : (sel > last);
  assign pen_amt = cfg.mode_short ? (last - sel) : (sel - last);

  assign offset = prod[szs_pkg::PROD_W-1:szs_pkg::FRAC_SHIFT];
  // price plus or minus a 40-bit offset never leaves the 48-bit signed range
  assign raw_calc = cfg.mode_short
    ? $signed(szs_pkg::STOP_W'(base)) + $signed(szs_pkg::STOP_W'(offset))
    : $signed(szs_pkg::STOP_W'(base)) - $signed(szs_pkg::STOP_W'(offset));

  assign accept    = (state == S_IDLE) && in_valid;
  assign scan_end  = (state == S_SCAN) && (scan_left == '0) && !rd_vld;
  assign div_start = scan_end && (cnt != '0);
  assign win_we    = (state == S_STORE);
  assign hist_we   = (state == S_EMIT) && res_ready;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign res_data  = held;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wp] <= {bar_lo, bar_hi};
    end
    win_rd <= win_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hp] <= raw;
    end
    hist_rd <= hist_mem[h_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bar_index   <= '0;
      wp          <= '0;
      hp          <= '0;
      stops_valid <= '0;
      scan_left   <= '0;
      h_left      <= '0;
      rd_vld      <= 1'b0;
      h_vld       <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN) && (scan_left != '0);
      h_vld  <= (state == S_HOLD) && (h_left != '0);
      if (clr_hist) begin
        stops_valid <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            bar_hi    <= in_high;
            bar_lo    <= in_low;
            bar_index <= bidx_eff;
            if (in_new) begin
              stops_valid <= '0;
            end
            sum       <= '0;
            cnt       <= '0;
            rd_first  <= 1'b1;
            scan_addr <= (wp == '0) ? szs_pkg::WIN_AW'(szs_pkg::WIN_DEPTH - 1)
                                    : wp - 1'b1;
            // first stop of a series skips the oldest penetration
            scan_left <= (bidx_eff == szs_pkg::IDX_W'(lb_p1)) ? szs_pkg::WIN_AW'(lb_c)
                                                               : szs_pkg::WIN_AW'(lb_p1);
            state     <= warm ? S_SCAN : S_STORE;
          end
        end
        S_SCAN: begin
          if (scan_left != '0) begin
            scan_left <= scan_left - 1'b1;
            scan_addr <= (scan_addr == '0) ? szs_pkg::WIN_AW'(szs_pkg::WIN_DEPTH - 1)
                                           : scan_addr - 1'b1;
          end
          if (rd_vld) begin
            last     <= sel;
            rd_first <= 1'b0;
            if (rd_first) begin
              base <= sel;
            end else if (pen_hit) begin
              sum <= sum + szs_pkg::SUM_W'(pen_amt);
              cnt <= cnt + 1'b1;
            end
          end
          if (scan_end) begin
            if (cnt == '0) begin
              mean  <= '0;
              state <= S_MUL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            // mean of 32-bit penetrations fits in 32 bits
            mean  <= div_q[szs_pkg::PRICE_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= szs_pkg::PROD_W'(cfg.coefficient) * szs_pkg::PROD_W'(mean);
          state <= S_RAW;
        end
        S_RAW: begin
          raw    <= raw_calc;
          held   <= raw_calc;
          h_addr <= (hp == '0) ? szs_pkg::HIST_AW'(szs_pkg::MAX_HOLD - 1) : hp - 1'b1;
          h_left <= hold_n;
          state  <= S_HOLD;
        end
        S_HOLD: begin
          if (h_left != '0) begin
            h_left <= h_left - 1'b1;
            h_addr <= (h_addr == '0) ? szs_pkg::HIST_AW'(szs_pkg::MAX_HOLD - 1)
                                     : h_addr - 1'b1;
          end
          if (h_vld) begin
            if (cfg.mode_short ? ($signed(hist_rd) < held) : ($signed(hist_rd) > held)) begin
              held <= $signed(hist_rd);
            end
          end
          if ((h_left == '0) && !h_vld) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            hp <= (hp == szs_pkg::HIST_AW'(szs_pkg::MAX_HOLD - 1)) ? '0 : hp + 1'b1;
            if (stops_valid != szs_pkg::HVAL_W'(szs_pkg::MAX_HOLD)) begin
              stops_valid <= stops_valid + 1'b1;
            end
            state <= S_STORE;
          end
        end
        S_STORE: begin
          wp <= (wp == szs_pkg::WIN_AW'(szs_pkg::WIN_DEPTH - 1)) ? '0 : wp + 1'b1;
          if (bar_index != szs_pkg::IDX_W'(szs_pkg::IDX_CAP)) begin
            bar_index <= bar_index + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/safezone_stop.sv @@
// top level of the safezone trailing stop: config registers and output register
//
//  channel   direction  fields (low bit up)
//  s_*       in         tdata: bar_high[31:0], bar_low[63:32]; tuser: new_series
//  m_*       out        tdata: stop_level[47:0] signed
//  cfg_*     in         index 0 mode_short, 1 lookback, 2 hold_count, 3 coefficient
//
// warming bar: goes straight to the window store; stop bar: scan, divide (skipped with no
// penetration), multiply, raw stop, hold over the stored stops, emit and store
// s_tready is high only while the sequencer is idle; a stop waits in the output
// register while the next bar is taken, and a full output register stalls the emit step
// rst is synchronous and clears the sequence, window pointer, history count and registers
module safezone_stop (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [63:0]                      s_tdata,   // bar_high, bar_low
  input  logic                             s_tuser,   // new_series
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [szs_pkg::STOP_W-1:0]       m_tdata,   // stop_level
  input  logic                             cfg_we,
  input  logic [szs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [szs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  szs_pkg::cfg_t                  cfg;
  logic                           clr_hist;
  logic                           res_valid;
  logic                           res_ready;
  logic [szs_pkg::STOP_W-1:0]     res_data;

  // changing direction invalidates the stored stops
  assign clr_hist = cfg_we && (cfg_index == szs_pkg::REG_MODE_SHORT)
                    && (cfg_data[0] != cfg.mode_short);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_short  <= 1'b0;
      cfg.lookback    <= szs_pkg::LB_W'(10);
      cfg.hold_count  <= szs_pkg::HC_W'(2);
      cfg.coefficient <= szs_pkg::COEF_W'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        szs_pkg::REG_MODE_SHORT:  cfg.mode_short  <= cfg_data[0];
        szs_pkg::REG_LOOKBACK:    cfg.lookback    <= cfg_data[szs_pkg::LB_W-1:0];
        szs_pkg::REG_HOLD_COUNT:  cfg.hold_count  <= cfg_data[szs_pkg::HC_W-1:0];
        szs_pkg::REG_COEFFICIENT: cfg.coefficient <= cfg_data[szs_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  szs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clr_hist  (clr_hist),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_high   (s_tdata[31:0]),
    .in_low    (s_tdata[63:32]),
    .in_new    (s_tuser),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res_data;
    end
  end

  // a bar transfer always puts the sequencer to work, so s_tready is low in the cycle after it
  ap_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer ready right after taking a bar");

  // a result is never offered while the sequencer is idle
  ap_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res_valid)
    else $error("result offered while idle");

  // a handed-off result lands in the output register
  ap_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("result lost between core and output register");

endmodule

@@ tb/tb_safezone_stop.sv @@
// testbench for safezone_stop: directed bar table, then random bar series checked by a stop predictor
module tb_safezone_stop;

  localparam int     SETTLE_CYCLES = 200;
  localparam longint PRICE_TOP     = 64'h0000_0000_FFFF_FFFF;
  localparam longint STOP_MAX      = (64'sd1 <<< (szs_pkg::STOP_W - 1)) - 1;
  localparam longint STOP_MIN      = -(64'sd1 <<< (szs_pkg::STOP_W - 1));

  typedef enum logic [0:0] {ROW_BAR, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [szs_pkg::CFG_IDX_W-1:0]      reg_idx;
    logic [szs_pkg::CFG_DATA_W-1:0]     reg_val;
    logic [szs_pkg::PRICE_W-1:0]        hi;
    logic [szs_pkg::PRICE_W-1:0]        lo;
    logic                               fresh;
    logic                               known;
    logic [szs_pkg::STOP_W-1:0]         known_stop;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [63:0]                      s_tdata = '0;   // bar_high[31:0], bar_low[63:32]
  logic                             s_tuser = 1'b0; // new_series
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [szs_pkg::STOP_W-1:0]       m_tdata;        // stop_level[47:0]
  logic                             cfg_we = 1'b0;
  logic [szs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [szs_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // mirror of the block: registers, price windows, raw stop history
  logic                             cfg_short = 1'b0;
  int                               cfg_lookback = 10;
  int                               cfg_hold = 2;
  int                               cfg_coef = 512;
  logic [szs_pkg::PRICE_W-1:0]      low_hist [szs_pkg::WIN_DEPTH];
  logic [szs_pkg::PRICE_W-1:0]      high_hist [szs_pkg::WIN_DEPTH];
  int                               win_ptr = 0;
  longint                           raw_stops [szs_pkg::MAX_HOLD];
  int                               raw_count = 0;
  int                               bars_seen = 0;

  logic [szs_pkg::STOP_W-1:0]       stops_due [$];
  int                               mismatches = 0;
  int                               send_idle_pct = 28;
  int                               recv_idle_pct = 62;
  plan_row_t                        plan [0:24];

  safezone_stop uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [szs_pkg::PRICE_W-1:0] bars_back(input logic from_highs,
                                                             input int k);
    int slot;
    slot = (win_ptr + szs_pkg::WIN_DEPTH - k) % szs_pkg::WIN_DEPTH;
    return from_highs ? high_hist[slot] : low_hist[slot];
  endfunction

  // advances the mirror by one bar; returns 1 when the bar yields a stop
  function automatic bit stop_for_bar(input logic [szs_pkg::PRICE_W-1:0] hi, lo,
                                      input logic fresh,
                                      output logic [szs_pkg::STOP_W-1:0] stop);
    int                            lb, hc, npen, cnt, k;
    longint unsigned               sum, mean, offset;
    logic [szs_pkg::PRICE_W-1:0]   cur, prev;
    longint                        raw, held;
    bit                            fired;
    lb = cfg_lookback < 1 ? 1 :
         (cfg_lookback > szs_pkg::MAX_LOOKBACK ? szs_pkg::MAX_LOOKBACK : cfg_lookback);
    hc = cfg_hold > szs_pkg::MAX_HOLD ? szs_pkg::MAX_HOLD : cfg_hold;
    fired = 1'b0;
    stop = '0;
    if (fresh) begin
      bars_seen = 0;
      raw_count = 0;
    end
    if (bars_seen >= lb + 1) begin
      // first stop of a series skips the bar 0 to bar 1 penetration
      npen = (bars_seen == lb + 1) ? lb - 1 : lb;
      sum = 0;
      cnt = 0;
      mean = 0;
      for (k = 1; k <= npen; k++) begin
        cur = bars_back(cfg_short, k);
        prev = bars_back(cfg_short, k + 1);
        if (!cfg_short && prev > cur) begin
          sum += prev - cur;
          cnt++;
        end
        if (cfg_short && cur > prev) begin
          sum += cur - prev;
          cnt++;
        end
      end
      if (cnt > 0) mean = sum / longint'(cnt);
      offset = (mean * longint'(cfg_coef)) >> szs_pkg::FRAC_SHIFT;
      if (cfg_short) raw = longint'(bars_back(1'b1, 1)) + longint'(offset);
      else raw = longint'(bars_back(1'b0, 1)) - longint'(offset);
      if (raw > STOP_MAX) raw = STOP_MAX;
      if (raw < STOP_MIN) raw = STOP_MIN;
      held = raw;
      for (k = 0; k < hc && k < raw_count; k++) begin
        if (!cfg_short && raw_stops[k] > held) held = raw_stops[k];
        if (cfg_short && raw_stops[k] < held) held = raw_stops[k];
      end
      for (k = szs_pkg::MAX_HOLD - 1; k > 0; k--) raw_stops[k] = raw_stops[k - 1];
      raw_stops[0] = raw;
      if (raw_count < szs_pkg::MAX_HOLD) raw_count++;
      stop = held[szs_pkg::STOP_W-1:0];
      fired = 1'b1;
    end
    low_hist[win_ptr] = lo;
    high_hist[win_ptr] = hi;
    win_ptr = (win_ptr + 1) % szs_pkg::WIN_DEPTH;
    if (bars_seen < szs_pkg::IDX_CAP) bars_seen++;
    return fired;
  endfunction

  function automatic plan_row_t cfg_row(input logic [szs_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [szs_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic plan_row_t bar_row(input logic [szs_pkg::PRICE_W-1:0] hi, lo,
                                        input logic fresh, input logic known,
                                        input logic [szs_pkg::STOP_W-1:0] stop);
    plan_row_t r;
    r = '0;
    r.kind = ROW_BAR;
    r.hi = hi;
    r.lo = lo;
    r.fresh = fresh;
    r.known = known;
    r.known_stop = stop;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input logic [szs_pkg::STOP_W-1:0] want, got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s expected %h got %h", mismatches, what, want, got);
  endtask

  task automatic write_reg(input logic [szs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [szs_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      szs_pkg::REG_MODE_SHORT: begin
        // a real mode flip drops the held stops
        if (val[0] != cfg_short) raw_count = 0;
        cfg_short = val[0];
      end
      szs_pkg::REG_LOOKBACK:    cfg_lookback = int'(val[szs_pkg::LB_W-1:0]);
      szs_pkg::REG_HOLD_COUNT:  cfg_hold = int'(val[szs_pkg::HC_W-1:0]);
      szs_pkg::REG_COEFFICIENT: cfg_coef = int'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_bar(input logic [szs_pkg::PRICE_W-1:0] hi, lo, input logic fresh,
                          input logic known, input logic [szs_pkg::STOP_W-1:0] known_stop);
    logic [szs_pkg::STOP_W-1:0] stop;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lo, hi};
    s_tuser <= fresh;
    do @(posedge clk); while (!s_tready);
    if (stop_for_bar(hi, lo, fresh, stop)) stops_due.push_back(known ? known_stop : stop);
  endtask

  // bars that yield no stop may still be in flight, so wait past the longest bar
  task automatic drain();
    s_tvalid <= 1'b0;
    while (stops_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_segment(input int bars);
    longint                           level, spread;
    logic [szs_pkg::PRICE_W-1:0]      hi, lo;
    logic [szs_pkg::CFG_DATA_W-1:0]   val;
    logic                             fresh;
    int                               pick, n;
    drain();
    write_reg(szs_pkg::REG_MODE_SHORT, szs_pkg::CFG_DATA_W'($urandom_range(1)));
    pick = $urandom_range(19);
    val = pick == 0 ? szs_pkg::CFG_DATA_W'(0) :
          pick == 1 ? szs_pkg::CFG_DATA_W'(64) :
          pick == 2 ? szs_pkg::CFG_DATA_W'($urandom_range(127, 65)) :
          szs_pkg::CFG_DATA_W'($urandom_range(8, 1));
    write_reg(szs_pkg::REG_LOOKBACK, val);
    pick = $urandom_range(9);
    val = pick == 0 ? szs_pkg::CFG_DATA_W'(0) :
          pick == 1 ? szs_pkg::CFG_DATA_W'(32) :
          pick == 2 ? szs_pkg::CFG_DATA_W'($urandom_range(63, 33)) :
          szs_pkg::CFG_DATA_W'($urandom_range(6));
    write_reg(szs_pkg::REG_HOLD_COUNT, val);
    pick = $urandom_range(9);
    val = pick == 0 ? szs_pkg::CFG_DATA_W'(0) :
          pick == 1 ? szs_pkg::CFG_DATA_W'(16'hFFFF) :
          pick == 2 ? szs_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)) :
          szs_pkg::CFG_DATA_W'($urandom_range(1024, 64));
    write_reg(szs_pkg::REG_COEFFICIENT, val);
    level = longint'($urandom);
    for (n = 0; n < bars; n++) begin
      // a segment may carry on the series left by the previous settings
      fresh = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) == 0);
      if (fresh) level = longint'($urandom);
      if ($urandom_range(99) < 8) begin
        hi = $urandom;
        lo = $urandom;
      end else begin
        level = level + longint'($urandom_range(32'h6_0000)) - 64'sh3_0000;
        if (level < 0) level = 0;
        if (level > PRICE_TOP) level = PRICE_TOP;
        spread = longint'($urandom_range(32'h2_0000));
        lo = level[szs_pkg::PRICE_W-1:0];
        hi = (level + spread > PRICE_TOP) ? '1 : szs_pkg::PRICE_W'(level + spread);
      end
      send_bar(hi, lo, fresh, 1'b0, '0);
    end
  endtask

  // result side: random backpressure and the check of every transfer
  always @(posedge clk) begin
    logic [szs_pkg::STOP_W-1:0] want;
    m_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (stops_due.size() == 0) begin
        log_mismatch("stop with none pending", 'x, m_tdata);
      end else begin
        want = stops_due.pop_front();
        if (m_tdata !== want) log_mismatch("stop_level", want, m_tdata);
      end
    end
  end

  initial begin
    int ph;
    plan = '{
      cfg_row(szs_pkg::REG_LOOKBACK, 16'd0),
      cfg_row(szs_pkg::REG_COEFFICIENT, 16'd0),
      bar_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0),
      bar_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0),
      bar_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 48'h0000_FFFF_FFFF),
      // raw stop drops to zero, held up by the previous one
      bar_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 48'h0000_FFFF_FFFF),
      cfg_row(szs_pkg::REG_HOLD_COUNT, 16'd0),
      bar_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 48'h0000_0000_0000),
      cfg_row(szs_pkg::REG_COEFFICIENT, 16'hFFFF),
      cfg_row(szs_pkg::REG_MODE_SHORT, 16'd1),
      bar_row(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 48'h0000_0000_0000),
      bar_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0),
      cfg_row(szs_pkg::REG_LOOKBACK, 16'd3),
      cfg_row(szs_pkg::REG_HOLD_COUNT, 16'd63),
      cfg_row(szs_pkg::REG_COEFFICIENT, 16'd256),
      bar_row(32'h0010_0000, 32'h000F_0000, 1'b1, 1'b0, '0),
      bar_row(32'h0012_0000, 32'h0010_0000, 1'b0, 1'b0, '0),
      bar_row(32'h0011_0000, 32'h000E_0000, 1'b0, 1'b0, '0),
      bar_row(32'h0015_0000, 32'h0012_0000, 1'b0, 1'b0, '0),
      bar_row(32'h0014_0000, 32'h0011_0000, 1'b0, 1'b0, '0),
      bar_row(32'h0018_0000, 32'h0013_0000, 1'b0, 1'b0, '0),
      bar_row(32'h0017_0000, 32'h0016_0000, 1'b0, 1'b0, '0),
      cfg_row(szs_pkg::REG_MODE_SHORT, 16'd0),
      bar_row(32'h0019_0000, 32'h0015_0000, 1'b0, 1'b0, '0),
      bar_row(32'h0020_0000, 32'h001F_0000, 1'b1, 1'b0, '0)
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_bar(plan[i].hi, plan[i].lo, plan[i].fresh, plan[i].known, plan[i].known_stop);
      end
    end
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 28 : ph == 1 ? 62 : 0;
      recv_idle_pct = ph == 0 ? 62 : ph == 1 ? 28 : 0;
      repeat (4) run_segment(100);
    end
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
